[hw/rtl/rsep_pkg.sv]
// Shared types and constants for the RGB Sobel edge bitmap packer.
// No dependencies; every other file imports this package.
package rsep_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int PIX_W      = 8;
	localparam int WID_W      = 7;
	localparam int HGT_W      = 16;
	localparam int THR_W      = 11;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = 10;
	localparam int GRAD_W     = 11;
	localparam int SQ_W       = 20;
	localparam int THR_SQ_W   = 2 * THR_W;
	localparam int PROD_W     = 20;
	localparam int FILL_W     = 3;

	// floor(x/3) == (x*683) >> 11 for every x below 2048
	localparam int GRAY_RECIP = 683;
	localparam int GRAY_SHIFT = 11;

	localparam logic [WID_W-1:0] WIDTH_MIN   = WID_W'(3);
	localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(MAX_WIDTH);
	localparam logic [HGT_W-1:0] HEIGHT_MIN  = HGT_W'(3);
	localparam logic [WID_W-1:0] WIDTH_RST   = WID_W'(50);
	localparam logic [HGT_W-1:0] HEIGHT_RST  = HGT_W'(50);
	localparam logic [THR_W-1:0] THRESH_RST  = THR_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_THRESHOLD = 2'd2
	} cfg_reg_t;

	// per-item control that rides down the pipeline
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             region;
		logic             last_col;
		logic             last_row;
	} item_ctl_t;

endpackage

[hw/rtl/rsep_pix_if.sv]
// Pixel channel: valid/ready handshake with one RGB pixel as payload.
// Depends on rsep_pkg.
interface rsep_pix_if;
	import rsep_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

[hw/rtl/rsep_byte_if.sv]
// Bitmap channel: valid/ready handshake with one packed edge byte as payload.
// Depends on rsep_pkg.
interface rsep_byte_if;
	import rsep_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] packed_bits;
	logic             row_end;
	logic             frame_end;

	modport source (output valid, output packed_bits, output row_end, output frame_end,
		input ready);
	modport sink   (input valid, input packed_bits, input row_end, input frame_end,
		output ready);

endinterface

[hw/rtl/rsep_line_store.sv]
// Two line memories (upper and middle row), synchronous read with registered data.
// Depends on rsep_pkg.
module rsep_line_store
	import rsep_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [PIX_W-1:0] wr_upper,
	input  logic [PIX_W-1:0] wr_middle,
	output logic [PIX_W-1:0] rd_upper_s1,
	output logic [PIX_W-1:0] rd_middle_s1
);

	logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
	logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_upper[wr_addr]  <= wr_upper;
			mem_middle[wr_addr] <= wr_middle;
		end
	end

	// read data holds while the item waits in stage 1
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_upper_s1  <= mem_upper[rd_addr];
			rd_middle_s1 <= mem_middle[rd_addr];
		end
	end

endmodule

[hw/rtl/rsep_grad.sv]
// Gray conversion, 3x3 window columns and Sobel gx/gy, registered into stage 2.
// Depends on rsep_pkg.
module rsep_grad
	import rsep_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [PIX_W-1:0]         red_s1,
	input  logic [PIX_W-1:0]         green_s1,
	input  logic [PIX_W-1:0]         blue_s1,
	input  logic [PIX_W-1:0]         upper_s1,
	input  logic [PIX_W-1:0]         middle_s1,
	output logic [PIX_W-1:0]         gray,
	output logic signed [GRAD_W-1:0] gx_s2,
	output logic signed [GRAD_W-1:0] gy_s2
);

	// win_q[0..2]: column two back (top, mid, bottom); win_q[3..5]: previous column
	logic [PIX_W-1:0]  win_q [6];
	logic [SUM_W-1:0]  rgb_sum;
	logic [PROD_W-1:0] gray_prod;
	logic [SUM_W-1:0]  gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [SUM_W+1:0] gx_diff, gy_diff;

	always_comb begin
		rgb_sum   = SUM_W'(red_s1) + SUM_W'(green_s1) + SUM_W'(blue_s1);
		gray_prod = PROD_W'(rgb_sum) * PROD_W'(GRAY_RECIP);
		gray      = gray_prod[GRAY_SHIFT +: PIX_W];

		gx_pos = SUM_W'(upper_s1) + (SUM_W'(middle_s1) << 1) + SUM_W'(gray);
		gx_neg = SUM_W'(win_q[0]) + (SUM_W'(win_q[1]) << 1) + SUM_W'(win_q[2]);
		gy_pos = SUM_W'(win_q[2]) + (SUM_W'(win_q[5]) << 1) + SUM_W'(gray);
		gy_neg = SUM_W'(win_q[0]) + (SUM_W'(win_q[3]) << 1) + SUM_W'(upper_s1);
		gx_diff = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
		gy_diff = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= upper_s1;
			win_q[4] <= middle_s1;
			win_q[5] <= gray;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2 <= gx_diff[GRAD_W-1:0];
			gy_s2 <= gy_diff[GRAD_W-1:0];
		end
	end

endmodule

[hw/rtl/rsep_mag.sv]
// Squared gradient magnitude (registered into stage 3) and threshold compare.
// Depends on rsep_pkg.
module rsep_mag
	import rsep_pkg::*;
(
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [GRAD_W-1:0] gx_s2,
	input  logic signed [GRAD_W-1:0] gy_s2,
	input  logic [THR_SQ_W-1:0]      thr_sq,
	output logic                     is_edge
);

	logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
	logic [SQ_W-1:0]            gx_sq_s3, gy_sq_s3;
	logic [SQ_W:0]              mag_sum;

	always_comb begin
		gx_sq = (2*GRAD_W)'(gx_s2) * (2*GRAD_W)'(gx_s2);
		gy_sq = (2*GRAD_W)'(gy_s2) * (2*GRAD_W)'(gy_s2);
	end

	// squares stay below 2^20, so the low bits hold the full value
	always_ff @(posedge clk) begin
		if (adv) begin
			gx_sq_s3 <= gx_sq[SQ_W-1:0];
			gy_sq_s3 <= gy_sq[SQ_W-1:0];
		end
	end

	always_comb begin
		mag_sum = (SQ_W+1)'(gx_sq_s3) + (SQ_W+1)'(gy_sq_s3);
		is_edge = THR_SQ_W'(mag_sum) >= thr_sq;
	end

endmodule

[hw/rtl/rsep_packer.sv]
// Packs edge flags MSB first into bytes and holds the output register.
// Depends on rsep_pkg and rsep_byte_if.
module rsep_packer
	import rsep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s3,
	input  item_ctl_t          ctl_s3,
	input  logic               is_edge,
	output logic               take_s3,
	rsep_byte_if.source        bitmap
);

	logic [PIX_W-1:0]  gather_q;
	logic [FILL_W-1:0] fill_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_bits_q;
	logic              out_row_end_q;
	logic              out_frame_end_q;

	logic              emit;
	logic              out_free;
	logic [PIX_W-1:0]  gather_next;

	always_comb begin
		out_free    = !out_valid_q || bitmap.ready;
		emit        = valid_s3 && ctl_s3.region && ((fill_q == '1) || ctl_s3.last_col);
		take_s3     = valid_s3 && (!emit || out_free);
		gather_next = gather_q | (PIX_W'(is_edge) << (FILL_W'(PIX_W - 1) - fill_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q    <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s3) begin
				if (emit || ctl_s3.last_col) begin
					gather_q <= '0;
					fill_q   <= '0;
				end else if (ctl_s3.region) begin
					gather_q <= gather_next;
					fill_q   <= fill_q + FILL_W'(1);
				end
			end
			if (take_s3 && emit) begin
				out_valid_q <= 1'b1;
			end else if (bitmap.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && emit) begin
			out_bits_q      <= gather_next;
			out_row_end_q   <= ctl_s3.last_col;
			out_frame_end_q <= ctl_s3.last_col && ctl_s3.last_row;
		end
	end

	assign bitmap.valid       = out_valid_q;
	assign bitmap.packed_bits = out_bits_q;
	assign bitmap.row_end     = out_row_end_q;
	assign bitmap.frame_end   = out_frame_end_q;

`ifndef NO_ASSERTIONS
	a_row_clears_gather: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s3 && ctl_s3.last_col) |=> (fill_q == '0 && gather_q == '0))
		else $error("packer state not cleared at row end");

	a_frame_end_in_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(bitmap.valid && bitmap.frame_end) |-> bitmap.row_end)
		else $error("frame end byte without row end");
`endif

endmodule

[hw/rtl/rgb_sobel_edge_bitmap_packer_top.sv]
// RGB Sobel edge bitmap packer: top level with config registers and pipeline control.
// A byte goes valid on bitmap after its closing pixel passes s1, s2, s3 and out_valid_q.
// Throughput: one pixel per cycle unless bitmap stalls (one read, one write port per store).
// Reset: arst_n clears counters, window, packer and valids; line stores are not cleared.
// Depends on rsep_pkg, rsep_pix_if, rsep_byte_if and the rsep_* submodules.
module rgb_sobel_edge_bitmap_packer_top
	import rsep_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	rsep_pix_if.sink             pixels,
	rsep_byte_if.source          bitmap
);

	// configuration registers
	logic [WID_W-1:0]    width_q;
	logic [HGT_W-1:0]    height_q;
	logic [THR_W-1:0]    thresh_q;
	logic [THR_SQ_W-1:0] thr_sq_q;

	// raster position of the next pixel
	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;

	// effective frame size and per-item flags for the incoming pixel
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;
	item_ctl_t        ctl_in;

	// pipeline: s1 = line store read data, s2 = gx/gy, s3 = squares
	logic             valid_s1, valid_s2, valid_s3;
	item_ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	logic [PIX_W-1:0] upper_s1, middle_s1;
	logic [PIX_W-1:0] gray;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic             is_edge;

	logic accept, adv1, adv2, take_s3;
	logic rdy1, rdy2, rdy3;

	// config write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thresh_q <= THRESH_RST;
			thr_sq_q <= THR_SQ_W'(THRESH_RST) * THR_SQ_W'(THRESH_RST);
		end else begin
			// squared threshold is registered from thresh_q, so it updates after thresh_q, while idle
			thr_sq_q <= THR_SQ_W'(thresh_q) * THR_SQ_W'(thresh_q);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:     width_q  <= cfg_data[WID_W-1:0];
					REG_HEIGHT:    height_q <= cfg_data[HGT_W-1:0];
					REG_THRESHOLD: thresh_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// clamp the frame size, then flag the incoming pixel
	always_comb begin
		if (width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;

		ctl_in.col      = col_q;
		ctl_in.last_col = (WID_W'(col_q) + WID_W'(1)) >= w_eff;
		ctl_in.last_row = ((HGT_W+1)'(row_q) + (HGT_W+1)'(1)) >= (HGT_W+1)'(h_eff);
		ctl_in.region   = (row_q >= HGT_W'(2)) && (col_q >= COL_W'(2));
	end

	// handshake chain: each stage moves when the one after it has room
	always_comb begin
		rdy3   = !valid_s3 || take_s3;
		adv2   = valid_s2 && rdy3;
		rdy2   = !valid_s2 || adv2;
		adv1   = valid_s1 && rdy2;
		rdy1   = !valid_s1 || adv1;
		accept = pixels.valid && rdy1;
	end

	assign pixels.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				if (ctl_in.last_col) begin
					col_q <= '0;
					row_q <= ctl_in.last_row ? '0 : row_q + HGT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			valid_s1 <= accept || (valid_s1 && !adv1);
			valid_s2 <= adv1 || (valid_s2 && !adv2);
			valid_s3 <= adv2 || (valid_s3 && !take_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl_in;
			red_s1   <= pixels.red;
			green_s1 <= pixels.green;
			blue_s1  <= pixels.blue;
		end
		if (adv1) begin
			ctl_s2 <= ctl_s1;
		end
		if (adv2) begin
			ctl_s3 <= ctl_s2;
		end
	end

	// line stores: read at accept, write back when the item leaves stage 1.
	// The same column comes around again only a full row later, so no forwarding.
	rsep_line_store u_line_store (
		.clk          (clk),
		.rd_en        (accept),
		.rd_addr      (col_q),
		.wr_en        (adv1),
		.wr_addr      (ctl_s1.col),
		.wr_upper     (middle_s1),
		.wr_middle    (gray),
		.rd_upper_s1  (upper_s1),
		.rd_middle_s1 (middle_s1)
	);

	rsep_grad u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv1),
		.red_s1    (red_s1),
		.green_s1  (green_s1),
		.blue_s1   (blue_s1),
		.upper_s1  (upper_s1),
		.middle_s1 (middle_s1),
		.gray      (gray),
		.gx_s2     (gx_s2),
		.gy_s2     (gy_s2)
	);

	rsep_mag u_mag (
		.clk     (clk),
		.adv     (adv2),
		.gx_s2   (gx_s2),
		.gy_s2   (gy_s2),
		.thr_sq  (thr_sq_q),
		.is_edge (is_edge)
	);

	rsep_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.ctl_s3   (ctl_s3),
		.is_edge  (is_edge),
		.take_s3  (take_s3),
		.bitmap   (bitmap)
	);

`ifndef NO_ASSERTIONS
	a_col_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl_in.last_col) |=> (col_q == '0))
		else $error("column did not wrap at row end");

	a_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ctl_in.last_col) |=> (col_q == $past(col_q) + COL_W'(1)))
		else $error("column did not advance by one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !rdy2) |=> valid_s1)
		else $error("stage 1 item lost under stall");
`endif

endmodule

[dv/tb_rgb_sobel_edge_bitmap_packer_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rgb_sobel_edge_bitmap_packer_top: random RGB frames in,
// packed edge bytes checked against an in-bench Sobel predictor.
// Depends on rsep_pkg, rsep_pix_if, rsep_byte_if and the RTL top.
module tb_rgb_sobel_edge_bitmap_packer_top;
	import rsep_pkg::*;

	localparam int RANDOM_ITEMS = 1450;
	localparam int QUIET_LIMIT  = 4000; // cycles with no item moving on either channel
	localparam int STALL_CYCLES = 300;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;    // drains s1, s2, s3 and the packer output register
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] bits;
		logic             row_end;
		logic             frame_end;
	} edge_byte_t;

	// who idles: receiver heavy first, then sender heavy, then nobody
	typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rsep_pix_if  pix_ch ();
	rsep_byte_if byte_ch ();

	rgb_sobel_edge_bitmap_packer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.bitmap    (byte_ch)
	);

	// stimulus and scoreboard storage
	rgb_pixel_t pixel_backlog[$];   // pixels waiting to be offered, front is on the bus
	edge_byte_t edge_bytes_due[$];  // predicted bytes, oldest first
	pace_t      pace;
	int         mismatch_count;
	int         pixels_queued;
	int         quiet_cycles;
	bit         pixel_taken;
	bit         stall_request;
	int         stall_left;

	// predictor state: mirrors the block's registers, line stores and window
	logic [WID_W-1:0] reg_width;
	logic [HGT_W-1:0] reg_height;
	logic [THR_W-1:0] reg_thresh;
	logic [PIX_W-1:0] upper_row [MAX_WIDTH];
	logic [PIX_W-1:0] middle_row [MAX_WIDTH];
	logic [PIX_W-1:0] win [6];      // two previous columns: top, middle, bottom each
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [7:0]       gather;
	logic [2:0]       fill_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// every input known from time zero; predictor starts at reset values
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_WIDTH;
		cfg_data       = '0;
		pix_ch.valid   = 1'b0;
		pix_ch.red     = '0;
		pix_ch.green   = '0;
		pix_ch.blue    = '0;
		byte_ch.ready  = 1'b0;
		reg_width      = WIDTH_RST;
		reg_height     = HEIGHT_RST;
		reg_thresh     = THRESH_RST;
		col_pos        = 0;
		row_pos        = 0;
		gather         = '0;
		fill_cnt       = '0;
		mismatch_count = 0;
		pixels_queued  = 0;
		quiet_cycles   = 0;
		pixel_taken    = 1'b0;
		stall_request  = 1'b0;
		stall_left     = 0;
		pace           = PACE_RX_SLOW;
		foreach (win[i]) win[i] = '0;
		foreach (upper_row[i]) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
	end

	// clamped geometry, as the block uses it
	function automatic int unsigned eff_width();
		if (reg_width < WIDTH_MIN)
			return 32'(WIDTH_MIN);
		if (reg_width > WIDTH_MAX)
			return MAX_WIDTH;
		return 32'(reg_width);
	endfunction

	function automatic int unsigned eff_height();
		return 32'((reg_height < HEIGHT_MIN) ? HEIGHT_MIN : reg_height);
	endfunction

	// pixels still needed to close the current frame from the predictor's position;
	// an index at or past the last position counts as the last one
	function automatic int unsigned frame_remaining();
		int unsigned w;
		int unsigned h;
		int unsigned in_row;
		int unsigned rows_after;
		w = eff_width();
		h = eff_height();
		in_row = (col_pos + 1 >= w) ? 1 : w - col_pos;
		rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
		return in_row + rows_after * w;
	endfunction

	// One accepted pixel: gray conversion, 3x3 Sobel on the valid region, threshold on
	// the squared magnitude, MSB-first packing. Queues a byte when 8 flags are in or
	// the row closes.
	function automatic void predict_edge_byte(rgb_pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned gray;
		int unsigned mag;
		int unsigned thr_sq;
		int          a0, a1, a2, b0, b2, c0, c1, c2, gx, gy;
		bit          last_col;
		bit          last_row;
		edge_byte_t  out_byte;
		w = eff_width();
		h = eff_height();
		col = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
		last_col = (col + 1 >= w);
		last_row = (row_pos + 1 >= h);
		gray = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;

		a0 = int'(win[0]); a1 = int'(win[1]); a2 = int'(win[2]);
		b0 = int'(win[3]); b2 = int'(win[5]);
		c0 = int'(upper_row[col]); c1 = int'(middle_row[col]); c2 = int'(gray);

		if (row_pos >= 2 && col >= 2) begin
			gx = (c0 + 2 * c1 + c2) - (a0 + 2 * a1 + a2);
			gy = (a2 + 2 * b2 + c2) - (a0 + 2 * b0 + c0);
			mag = gx * gx + gy * gy;
			thr_sq = int'(reg_thresh) * int'(reg_thresh);
			gather[3'd7 - fill_cnt] = (mag >= thr_sq);
			fill_cnt = fill_cnt + 3'd1;
			if (fill_cnt == 3'd0 || last_col) begin
				out_byte.bits      = gather;
				out_byte.row_end   = last_col;
				out_byte.frame_end = last_col && last_row;
				edge_bytes_due.push_back(out_byte);
				gather   = '0;
				fill_cnt = '0;
			end
		end

		win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
		win[3] = c0[7:0]; win[4] = c1[7:0]; win[5] = gray[7:0];
		upper_row[col]  = c1[7:0];
		middle_row[col] = gray[7:0];

		if (last_col) begin
			col_pos  = 0;
			gather   = '0;
			fill_cnt = '0;
			row_pos  = last_row ? 0 : (row_pos + 1) & 32'hFFFF;
		end else begin
			col_pos = col + 1;
		end
	endfunction

	function automatic bit sender_go();
		case (pace)
			PACE_RX_SLOW: return $urandom_range(99) >= 23;
			PACE_TX_SLOW: return $urandom_range(99) >= 72;
			default:      return 1'b1;
		endcase
	endfunction

	function automatic bit receiver_go();
		case (pace)
			PACE_RX_SLOW: return $urandom_range(99) >= 72;
			PACE_TX_SLOW: return $urandom_range(99) >= 23;
			default:      return 1'b1;
		endcase
	endfunction

	// Pixel driver. Acceptance is seen at the rising edge; the bus changes at the
	// falling edge. Valid holds with the same pixel until it is taken.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			predict_edge_byte(pixel_backlog[0]);
			void'(pixel_backlog.pop_front());
			pixel_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!pix_ch.valid || pixel_taken)) begin
			pixel_taken = 1'b0;
			if (pixel_backlog.size() != 0 && sender_go()) begin
				pix_ch.valid <= 1'b1;
				pix_ch.red   <= pixel_backlog[0].red;
				pix_ch.green <= pixel_backlog[0].green;
				pix_ch.blue  <= pixel_backlog[0].blue;
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Byte monitor. Ready is set at the falling edge; a pending stall request starts
	// a long hold-off as soon as a byte is waiting, so the pipeline backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_request && byte_ch.valid) begin
				stall_left    = STALL_CYCLES;
				stall_request = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				byte_ch.ready <= 1'b0;
			end else begin
				byte_ch.ready <= receiver_go();
			end
		end
	end

	always @(posedge clk) begin
		edge_byte_t got;
		edge_byte_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			got.bits      = byte_ch.packed_bits;
			got.row_end   = byte_ch.row_end;
			got.frame_end = byte_ch.frame_end;
			if (edge_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected byte bits=%02h row_end=%b frame_end=%b",
						$realtime, got.bits, got.row_end, got.frame_end);
			end else begin
				want = edge_bytes_due.pop_front();
				if (got.bits !== want.bits || got.row_end !== want.row_end ||
					got.frame_end !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: byte mismatch exp bits=%02h row_end=%b frame_end=%b, %s",
							$realtime, want.bits, want.row_end, want.frame_end,
							$sformatf("got bits=%02h row_end=%b frame_end=%b",
								got.bits, got.row_end, got.frame_end));
				end
			end
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (byte_ch.valid && byte_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic push_pixel(input int r, input int g, input int b);
		rgb_pixel_t px;
		px.red   = r[7:0];
		px.green = g[7:0];
		px.blue  = b[7:0];
		pixel_backlog.push_back(px);
		pixels_queued++;
	endtask

	// Wait until every pixel is taken and every byte has come out, then give the
	// pipeline time to empty: the last pixel of a pause may produce no byte.
	task automatic settle();
		while (pixel_backlog.size() != 0 || edge_bytes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write while idle; the predictor takes the new value at the same point
	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		case (idx)
			REG_WIDTH:     reg_width  = value[WID_W-1:0];
			REG_HEIGHT:    reg_height = value[HGT_W-1:0];
			REG_THRESHOLD: reg_thresh = value[THR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Frame content: fully random pixels, or blocks of dark and bright with a little
	// jitter so that thresholds land on both sides.
	task automatic push_frame(input int unsigned count, input int unsigned w, input bit blocky);
		int base;
		for (int unsigned i = 0; i < count; i++) begin
			if (blocky) begin
				base = (((i % w) / 3 + (i / w) / 2) % 2) ? 200 : 40;
				push_pixel(base + $urandom_range(15), base + $urandom_range(15),
					base + $urandom_range(15));
			end else begin
				push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
			end
		end
	endtask

	// vertical step: black left column, white right column, flat rows
	task automatic push_step_frame();
		for (int r = 0; r < 3; r++) begin
			push_pixel(0, 0, 0);
			push_pixel(1, 1, 0);
			push_pixel(255, 255, 255);
		end
	endtask

	initial begin
		int unsigned w_val;
		int unsigned h_val;
		int unsigned t_val;
		int unsigned pick;
		bit          stall_used;
		stall_used = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Flat black 3x3 with threshold zero: the one output pixel is an edge, and
		// the partial byte is zero-filled at row end.
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_THRESHOLD, 0);
		repeat (9) push_pixel(0, 0, 0);
		settle();

		// Largest horizontal gradient (gx = 1020, gy = 0) right at the threshold:
		// equality counts as an edge.
		write_reg(REG_THRESHOLD, 1020);
		push_step_frame();
		settle();

		// Same step, threshold at its top: no gradient can reach it. Width and height
		// below their minimum are clamped to 3.
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 1);
		write_reg(REG_THRESHOLD, 2047);
		push_step_frame();
		settle();

		// Random part.
		pixels_queued = 0;
		pace = PACE_RX_SLOW;

		// Registers changed mid-frame: a tall frame is cut short by a smaller height
		// and a narrower width while the column and row indexes sit past the new ends.
		write_reg(REG_WIDTH, 12);
		write_reg(REG_HEIGHT, 65535);
		write_reg(REG_THRESHOLD, $urandom_range(20, 400));
		push_frame(3 * 12 + 9, 12, 1'b0);
		settle();
		write_reg(REG_WIDTH, 5);
		write_reg(REG_HEIGHT, 3);
		push_frame(frame_remaining(), eff_width(), 1'b0);

		while (pixels_queued < RANDOM_ITEMS) begin
			settle();
			if (pixels_queued < RANDOM_ITEMS / 3)
				pace = PACE_RX_SLOW;
			else if (pixels_queued < 2 * RANDOM_ITEMS / 3)
				pace = PACE_TX_SLOW;
			else
				pace = PACE_FULL;

			pick = $urandom_range(99);
			if (pick < 70)
				w_val = $urandom_range(3, 16);
			else if (pick < 80)
				w_val = MAX_WIDTH;
			else if (pick < 85)
				w_val = $urandom_range(2);
			else if (pick < 90)
				w_val = $urandom_range(MAX_WIDTH + 1, 127);
			else
				w_val = $urandom_range(17, MAX_WIDTH - 1);

			pick = $urandom_range(99);
			if (pick < 80)
				h_val = $urandom_range(3, 5);
			else if (pick < 90)
				h_val = $urandom_range(2);
			else
				h_val = $urandom_range(6, 8);

			pick = $urandom_range(99);
			if (pick < 10)
				t_val = 0;
			else if (pick < 20)
				t_val = 2047;
			else if (pick < 30)
				t_val = $urandom_range(2047);
			else
				t_val = $urandom_range(20, 400);

			// once, with nobody idling: a wide frame while the receiver holds off
			if (pace == PACE_FULL && !stall_used) begin
				w_val = MAX_WIDTH;
				h_val = 5;
				stall_request = 1'b1;
				stall_used = 1'b1;
			end

			write_reg(REG_WIDTH, w_val);
			write_reg(REG_HEIGHT, h_val);
			write_reg(REG_THRESHOLD, t_val);
			push_frame(frame_remaining(), eff_width(), 1'($urandom_range(1)));
		end

		settle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && edge_bytes_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
